### rtl/spramp_pkg.sv
package spramp_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_ABORT = 2'd2;

	// Motion shape held while a motion runs.
	localparam logic [1:0] SHAPE_IDLE   = 2'd0;
	localparam logic [1:0] SHAPE_RAMP   = 2'd1;
	localparam logic [1:0] SHAPE_SCURVE = 2'd2;

	// The motion fraction u is an unsigned Q0.16 number.
	localparam int U_BITS = 16;
	localparam int U_HALF = 1 << (U_BITS - 1);
	localparam int CNT_W  = $clog2(U_BITS + 1);
	localparam int TBL_W  = 16;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint          ONE_Q30 = 64'sd1073741824;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DIV    = 8'b0000_0010,
		ST_LOOKUP = 8'b0000_0100,
		ST_CMUL   = 8'b0000_1000,
		ST_BSETUP = 8'b0001_0000,
		ST_BMUL   = 8'b0010_0000,
		ST_ROUND  = 8'b0100_0000,
		ST_FINAL  = 8'b1000_0000
	} state_t;

	// Cosine in Q30 for an angle in [0, pi/2] given in Q30, ten series terms.
	// Used only while the curve table is built at elaboration.
	function automatic longint cos_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (x * x) >> 30;
		term = longint'(ONE_Q30);
		sum  = ONE_Q30;
		term = ((term * x2) >> 30) / 64'd2;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd132;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd182;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd240;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd306;
		sum  = sum - longint'(term);
		return sum;
	endfunction

endpackage

### rtl/setpoint_ramp_scurve_generator.sv
// Setpoint ramp generator: moves a value from a start to a target over a number of
// millisecond ticks, along a linear ramp or a raised-cosine s-curve.
// Input channel s_*: op in s_tuser (tick, start, abort); s_tdata holds shape, start value,
// target value and duration. Output channel m_*: value in m_tdata, write_valid and
// busy_res in m_tuser. Every request yields exactly one result.
// Start, abort and idle ticks, as well as the tick that ends a motion, are answered
// directly: the result is registered at the edge the request is taken.
// A tick during a motion runs through one shared shift-add/subtract unit: a 16-step
// divide for the fraction, for the s-curve a table lookup and a 17-step interpolation
// multiply, then a 17-step blend multiply and rounding. A linear tick passes the states
// DIV, BSETUP, BMUL, ROUND and FINAL, an s-curve tick DIV, LOOKUP, CMUL, BSETUP, BMUL,
// ROUND and FINAL; the result is loaded as FINAL is left, and the input is not ready until then.
// CURVE_TABLE_DEPTH must be a power of two.
// Reset clears the motion (idle) and empties the output register.
// When the receiver stalls, the held result stays in place and no new request is
// taken until the output register can be loaded again.
module setpoint_ramp_scurve_generator #(
	parameter int VALUE_WIDTH       = 32,
	parameter int DURATION_WIDTH    = 24,
	parameter int CURVE_TABLE_DEPTH = 256,
	localparam int IN_W  = ((1 + 2 * VALUE_WIDTH + DURATION_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// shape, start_value, target_value, duration_ticks, zero padding
	input  logic [IN_W-1:0]  s_tdata,
	// op
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// value, zero padding
	output logic [OUT_W-1:0] m_tdata,
	// write_valid, busy_res
	output logic [1:0]       m_tuser
);

	localparam int VW    = VALUE_WIDTH;
	localparam int DW    = DURATION_WIDTH;
	localparam int UB    = spramp_pkg::U_BITS;
	localparam int AW    = VW + UB + 2;
	localparam int MC_W  = VW + 1;
	localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH);

	function automatic logic [spramp_pkg::TBL_W-1:0] curve_entry(input int idx);
		longint unsigned j;
		longint unsigned x;
		longint          c;
		longint          s;
		logic            mirror;
		mirror = (2 * idx > CURVE_TABLE_DEPTH);
		j = mirror ? 64'(CURVE_TABLE_DEPTH - idx) : 64'(idx);
		x = (spramp_pkg::PI_Q30 * j) / CURVE_TABLE_DEPTH;
		c = spramp_pkg::cos_q30(x);
		if (mirror) begin
			c = -c;
		end
		s = ((spramp_pkg::ONE_Q30 - c) + 64'sd16384) >>> 15;
		if (s < 0) begin
			s = 0;
		end
		if (s > 65535) begin
			s = 65535;
		end
		return s[spramp_pkg::TBL_W-1:0];
	endfunction

	logic [spramp_pkg::TBL_W-1:0] curve_rom [CURVE_TABLE_DEPTH];

	for (genvar gi = 0; gi < CURVE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [spramp_pkg::TBL_W-1:0] ENTRY = curve_entry(gi);
		assign curve_rom[gi] = ENTRY;
	end

	// Input fields.
	logic [1:0]          op;
	logic                shape;
	logic signed [VW-1:0] start_value;
	logic signed [VW-1:0] target_value;
	logic [DW-1:0]       duration_ticks;

	assign op             = s_tuser;
	assign shape          = s_tdata[0];
	assign start_value    = s_tdata[VW:1];
	assign target_value   = s_tdata[2*VW:VW+1];
	assign duration_ticks = s_tdata[2*VW+DW:2*VW+1];

	spramp_pkg::state_t state_q;
	logic [1:0]          active_q;
	logic [DW-1:0]       total_q;
	logic [DW-1:0]       elapsed_q;
	logic                out_valid_q;
	logic [VW-1:0]       value_q;
	logic                wr_q;
	logic                busy_q;
	logic [VW-1:0]       origin_q;
	logic [VW-1:0]       goal_q;
	logic [VW:0]         diff_q;
	logic [AW-1:0]       acc_q;
	logic [UB:0]         u_q;
	logic [UB:0]         mplr_q;
	logic [MC_W-1:0]     mcand_q;
	logic [spramp_pkg::TBL_W-1:0] a_q;
	logic [spramp_pkg::CNT_W-1:0] cnt_q;

	logic          accept;
	logic          out_free;
	logic          active_on;
	logic [DW-1:0] el_inc;
	logic          tick_end;
	logic          tick_go;
	logic          load_out;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == spramp_pkg::ST_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign active_on = (active_q != spramp_pkg::SHAPE_IDLE);
	assign el_inc    = (elapsed_q < total_q) ? elapsed_q + 1'b1 : elapsed_q;
	assign tick_end  = (el_inc >= total_q);
	assign tick_go   = accept && (op == spramp_pkg::OP_TICK) && active_on && !tick_end;
	assign load_out  = (accept && !tick_go) || ((state_q == spramp_pkg::ST_FINAL) && out_free);

	// Shared unit: the accumulator shifts left by one and either subtracts the duration
	// (divide steps) or adds the multiplicand when the top multiplier bit is set.
	logic          div_mode;
	logic [AW-1:0] shifted;
	logic [AW-1:0] addend;
	logic [AW:0]   sum_w;
	logic          carry;

	assign div_mode = (state_q == spramp_pkg::ST_DIV);
	assign shifted  = {acc_q[AW-2:0], 1'b0};
	assign addend   = div_mode ? ~AW'(total_q) : (mplr_q[UB] ? AW'(mcand_q) : '0);
	assign sum_w    = (AW+1)'(shifted) + (AW+1)'(addend) + (AW+1)'(div_mode);
	assign carry    = sum_w[AW];

	// Curve table interpolation operands.
	logic [IDX_W-1:0] idx_w;
	logic [IDX_W-1:0] idx_nx;
	logic [UB-1:0]    frac_w;
	logic [UB:0]      a_ext;
	logic [UB:0]      b_raw;
	logic [UB:0]      b_w;
	logic [UB:0]      cdiff;
	logic [2*UB:0]    cm_w;
	logic [UB:0]      curve_u;

	assign idx_w   = u_q[UB-1 -: IDX_W];
	assign idx_nx  = idx_w + 1'b1;
	assign frac_w  = u_q[UB-1:0] << IDX_W;
	assign a_ext   = (UB+1)'(curve_rom[idx_w]);
	// The entry past the end of the table is one.
	assign b_raw   = (idx_w == IDX_W'(CURVE_TABLE_DEPTH - 1)) ? ((UB+1)'(1) << UB)
	                 : (UB+1)'(curve_rom[idx_nx]);
	assign b_w     = (b_raw < a_ext) ? a_ext : b_raw;
	assign cdiff   = b_w - a_ext;
	assign cm_w    = acc_q[2*UB:0] + (2*UB+1)'(spramp_pkg::U_HALF);
	assign curve_u = (UB+1)'(a_q) + cm_w[2*UB:UB];

	logic [VW:0]   mag_w;
	logic [VW-1:0] r_w;
	logic [VW-1:0] blend_w;

	assign mag_w   = diff_q[VW] ? (~diff_q + 1'b1) : diff_q;
	assign r_w     = acc_q[UB +: VW];
	assign blend_w = diff_q[VW] ? origin_q - r_w : origin_q + r_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spramp_pkg::ST_IDLE;
			active_q    <= spramp_pkg::SHAPE_IDLE;
			total_q     <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				spramp_pkg::ST_IDLE: begin
					if (accept) begin
						case (op)
							spramp_pkg::OP_START: begin
								if (duration_ticks == '0) begin
									active_q <= spramp_pkg::SHAPE_IDLE;
								end else begin
									active_q  <= shape ? spramp_pkg::SHAPE_SCURVE
									             : spramp_pkg::SHAPE_RAMP;
									total_q   <= duration_ticks;
									elapsed_q <= '0;
								end
							end
							spramp_pkg::OP_ABORT: begin
								active_q <= spramp_pkg::SHAPE_IDLE;
							end
							spramp_pkg::OP_TICK: begin
								if (active_on) begin
									elapsed_q <= el_inc;
									if (tick_end) begin
										active_q <= spramp_pkg::SHAPE_IDLE;
									end else begin
										state_q <= spramp_pkg::ST_DIV;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				spramp_pkg::ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= (active_q == spramp_pkg::SHAPE_SCURVE)
						           ? spramp_pkg::ST_LOOKUP : spramp_pkg::ST_BSETUP;
					end
				end
				spramp_pkg::ST_LOOKUP: begin
					state_q <= spramp_pkg::ST_CMUL;
				end
				spramp_pkg::ST_CMUL: begin
					if (cnt_q == '0) begin
						state_q <= spramp_pkg::ST_BSETUP;
					end
				end
				spramp_pkg::ST_BSETUP: begin
					state_q <= spramp_pkg::ST_BMUL;
				end
				spramp_pkg::ST_BMUL: begin
					if (cnt_q == '0) begin
						state_q <= spramp_pkg::ST_ROUND;
					end
				end
				spramp_pkg::ST_ROUND: begin
					state_q <= spramp_pkg::ST_FINAL;
				end
				spramp_pkg::ST_FINAL: begin
					if (out_free) begin
						state_q <= spramp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= spramp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spramp_pkg::ST_IDLE: begin
				if (accept) begin
					value_q <= '0;
					wr_q    <= 1'b0;
					busy_q  <= 1'b0;
					case (op)
						spramp_pkg::OP_START: begin
							if (duration_ticks == '0) begin
								value_q <= target_value;
								wr_q    <= 1'b1;
							end else begin
								busy_q   <= 1'b1;
								origin_q <= start_value;
								goal_q   <= target_value;
								diff_q   <= {target_value[VW-1], target_value}
								            - {start_value[VW-1], start_value};
							end
						end
						spramp_pkg::OP_ABORT: begin
						end
						spramp_pkg::OP_TICK: begin
							if (active_on && tick_end) begin
								value_q <= goal_q;
								wr_q    <= 1'b1;
							end
							acc_q <= AW'(el_inc);
							u_q   <= '0;
							cnt_q <= spramp_pkg::CNT_W'(UB - 1);
						end
						default: begin
							busy_q <= active_on;
						end
					endcase
				end
			end
			spramp_pkg::ST_DIV: begin
				acc_q <= carry ? sum_w[AW-1:0] : shifted;
				u_q   <= {u_q[UB-1:0], carry};
				cnt_q <= cnt_q - 1'b1;
			end
			spramp_pkg::ST_LOOKUP: begin
				a_q     <= curve_rom[idx_w];
				mcand_q <= MC_W'(cdiff);
				mplr_q  <= {1'b0, frac_w};
				acc_q   <= '0;
				cnt_q   <= spramp_pkg::CNT_W'(UB);
			end
			spramp_pkg::ST_CMUL, spramp_pkg::ST_BMUL: begin
				acc_q  <= sum_w[AW-1:0];
				mplr_q <= {mplr_q[UB-1:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
			end
			spramp_pkg::ST_BSETUP: begin
				mplr_q  <= (active_q == spramp_pkg::SHAPE_SCURVE) ? curve_u : u_q;
				mcand_q <= mag_w;
				acc_q   <= '0;
				cnt_q   <= spramp_pkg::CNT_W'(UB);
			end
			spramp_pkg::ST_ROUND: begin
				acc_q <= acc_q + AW'(spramp_pkg::U_HALF);
			end
			spramp_pkg::ST_FINAL: begin
				if (out_free) begin
					value_q <= blend_w;
					wr_q    <= 1'b1;
					busy_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(value_q);
	assign m_tuser  = {busy_q, wr_q};

`ifndef SYNTHESIS
	// The divide remainder always stays below the duration.
	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spramp_pkg::ST_DIV) |-> (acc_q < AW'(total_q)))
		else $error("divide remainder not below duration");

	// The sequencer only runs while a motion is active.
	a_seq_needs_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != spramp_pkg::ST_IDLE) |-> active_on)
		else $error("sequencer busy without an active motion");

	// During a motion elapsed time never passes the duration.
	a_elapsed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_on |-> (elapsed_q < total_q))
		else $error("elapsed ticks reached duration while active");

	// A result without a write carries a zero value.
	a_zero_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (value_q == '0))
		else $error("nonzero value without write");

	// Leaving the final step always presents the blended result.
	a_final_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == spramp_pkg::ST_FINAL) && out_free) |=> (m_tvalid && m_tuser[0]))
		else $error("final step did not present a result");
`endif

endmodule
